### src/tccw_pkg.sv
// ============================================================================
// Text console character writer package
// Shared constants, codes and types for the console controller and datapath.
// ============================================================================
package tccw_pkg;

   // Default geometry of the console.
   localparam int DEF_SCREEN_COLUMNS = 80;
   localparam int DEF_SCREEN_ROWS    = 25;
   localparam int DEF_MEMORY_CELLS   = 8192;

   // Fixed field widths of the stream payloads.
   localparam int CHAR_W     = 8;
   localparam int READ_ADDR_W = 13;
   localparam int OFFSET_W   = 13;
   localparam int COLUMN_W   = 7;
   localparam int ROW_W      = 5;
   localparam int CELL_W     = 16;
   localparam int OPCODE_W   = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_ATTR  = 1'b0;
   localparam logic CSR_IDX_BLANK = 1'b1;

   // Values after reset.
   localparam logic [7:0]        RESET_ATTR  = 8'h07;
   localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0720;

   // Control characters.
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_FF  = 8'h0C;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_DEL = 8'h7F;

   // Request operation codes.
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUT   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // Class of a put character.
   typedef enum logic [2:0] {
      KIND_NUL,
      KIND_BS,
      KIND_DEL,
      KIND_CR,
      KIND_FF,
      KIND_LF,
      KIND_PRINT
   } kind_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_ERASE,
      ST_LINE,
      ST_COPY,
      ST_REBASE,
      ST_BLANK,
      ST_SCROLL,
      ST_AFTER,
      ST_CLEAR,
      ST_RESULT
   } state_type;

   // Datapath commands, one per cycle.
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_INIT_WRITE,
      CMD_CLEAR_WRITE,
      CMD_HOME,
      CMD_BS,
      CMD_ERASE,
      CMD_CR,
      CMD_UNWRAP,
      CMD_ROW_DOWN,
      CMD_COPY,
      CMD_REBASE,
      CMD_BLANK_WRITE,
      CMD_SCROLL,
      CMD_PUT,
      CMD_READ_RESULT
   } cmd_type;

   // Datapath status seen by the controller.
   typedef struct packed {
      op_type   op;
      kind_type kind;
      logic     column_zero;
      logic     column_wrap;
      logic     row_last;
      logic     needs_copy;
      logic     mem_last;
      logic     view_last;
      logic     cols_last;
      logic     out_free;
   } stat_type;

   // Classify a character byte.
   function automatic kind_type char_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         CH_NUL:  k = KIND_NUL;
         CH_BS:   k = KIND_BS;
         CH_DEL:  k = KIND_DEL;
         CH_CR:   k = KIND_CR;
         CH_FF:   k = KIND_FF;
         CH_LF:   k = KIND_LF;
         default: k = KIND_PRINT;
      endcase
      return k;
   endfunction

endpackage

### src/text_console_char_writer_top.sv
// ============================================================================
// Text console character writer
// Text-mode console engine with a cell memory, scrolling view and cursor.
//
//   Channel | Direction | Payload
//   req     | in        | tuser: opcode; tdata: char_code, read_address
//   rsp     | out       | tdata: start_offset, cursor_offset, column, row,
//           |           |        read_data
//   csr     | in/out    | char_attribute at 0x0, blank_cell at 0x4
//
// One item at a time. FF, LF and a printable character at a pending wrap
// move to the next line; on the last row that line move writes a blank line
// below the view and scrolls, after first copying the view back to offset 0
// when the blank line would not fit in memory. A clear fills the whole
// memory with the blank cell. After reset the memory is filled with the
// blank cell, during which req_tready stays low. A stalled result waits in
// the output register while the next item is accepted.
// ============================================================================
module text_console_char_writer_top #(
   parameter int SCREEN_COLUMNS = tccw_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tccw_pkg::DEF_SCREEN_ROWS,
   parameter int MEMORY_CELLS   = tccw_pkg::DEF_MEMORY_CELLS
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] char_code, [20:8] read_address, [23:21] zero
   input  logic [tccw_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  logic [tccw_pkg::OPCODE_W-1:0]   req_tuser,
   // Result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [12:0] start_offset, [25:13] cursor_offset, [32:26] column,
   // [37:33] row, [53:38] read_data, [55:54] zero
   output logic [tccw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tccw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tccw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tccw_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   tccw_pkg::cmd_type  cmd;
   tccw_pkg::stat_type stat;

   // Configuration accesses always complete in the access cycle.
   assign csr_pready = 1'b1;

   // Sequencer.
   tccw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Memory, registers and result stage.
   tccw_dpath #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS),
      .MEMORY_CELLS   (MEMORY_CELLS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

### src/tccw_ctrl.sv
// ============================================================================
// Text console controller
// State machine that sequences the datapath through each console operation.
// ============================================================================
module tccw_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  tccw_pkg::stat_type stat,
   output tccw_pkg::cmd_type  cmd
);

   tccw_pkg::state_type state_ff;
   tccw_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tccw_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tccw_pkg::ST_INIT: begin
            if (stat.mem_last) begin
               state_in = tccw_pkg::ST_IDLE;
            end
         end
         tccw_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = tccw_pkg::ST_DISPATCH;
            end
         end
         tccw_pkg::ST_DISPATCH: begin
            unique case (stat.op)
               tccw_pkg::OP_PUT: begin
                  unique case (stat.kind)
                     tccw_pkg::KIND_BS: begin
                        state_in = stat.column_zero ? tccw_pkg::ST_RESULT
                                                    : tccw_pkg::ST_ERASE;
                     end
                     tccw_pkg::KIND_DEL:   state_in = tccw_pkg::ST_ERASE;
                     tccw_pkg::KIND_FF:    state_in = tccw_pkg::ST_LINE;
                     tccw_pkg::KIND_LF:    state_in = tccw_pkg::ST_LINE;
                     tccw_pkg::KIND_PRINT: begin
                        state_in = stat.column_wrap ? tccw_pkg::ST_LINE
                                                    : tccw_pkg::ST_RESULT;
                     end
                     default:              state_in = tccw_pkg::ST_RESULT;
                  endcase
               end
               tccw_pkg::OP_CLEAR: state_in = tccw_pkg::ST_CLEAR;
               default:            state_in = tccw_pkg::ST_RESULT;
            endcase
         end
         tccw_pkg::ST_ERASE:  state_in = tccw_pkg::ST_RESULT;
         tccw_pkg::ST_LINE: begin
            priority if (!stat.row_last) begin
               state_in = tccw_pkg::ST_AFTER;
            end else if (stat.needs_copy) begin
               state_in = tccw_pkg::ST_COPY;
            end else begin
               state_in = tccw_pkg::ST_BLANK;
            end
         end
         tccw_pkg::ST_COPY: begin
            if (stat.view_last) begin
               state_in = tccw_pkg::ST_REBASE;
            end
         end
         tccw_pkg::ST_REBASE: state_in = tccw_pkg::ST_BLANK;
         tccw_pkg::ST_BLANK: begin
            if (stat.cols_last) begin
               state_in = tccw_pkg::ST_SCROLL;
            end
         end
         tccw_pkg::ST_SCROLL: state_in = tccw_pkg::ST_AFTER;
         tccw_pkg::ST_AFTER:  state_in = tccw_pkg::ST_RESULT;
         tccw_pkg::ST_CLEAR: begin
            if (stat.mem_last) begin
               state_in = tccw_pkg::ST_RESULT;
            end
         end
         tccw_pkg::ST_RESULT: begin
            if (stat.out_free) begin
               state_in = tccw_pkg::ST_IDLE;
            end
         end
         default: state_in = tccw_pkg::ST_IDLE;
      endcase
   end

   // Commands and handshake.
   always_comb begin
      cmd        = tccw_pkg::CMD_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         tccw_pkg::ST_INIT: cmd = tccw_pkg::CMD_INIT_WRITE;
         tccw_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd = tccw_pkg::CMD_LOAD;
            end
         end
         tccw_pkg::ST_DISPATCH: begin
            unique case (stat.op)
               tccw_pkg::OP_PUT: begin
                  unique case (stat.kind)
                     tccw_pkg::KIND_BS: begin
                        if (!stat.column_zero) begin
                           cmd = tccw_pkg::CMD_BS;
                        end
                     end
                     tccw_pkg::KIND_CR: cmd = tccw_pkg::CMD_CR;
                     tccw_pkg::KIND_PRINT: begin
                        cmd = stat.column_wrap ? tccw_pkg::CMD_UNWRAP
                                               : tccw_pkg::CMD_PUT;
                     end
                     default: cmd = tccw_pkg::CMD_NONE;
                  endcase
               end
               tccw_pkg::OP_CLEAR: cmd = tccw_pkg::CMD_HOME;
               default:            cmd = tccw_pkg::CMD_NONE;
            endcase
         end
         tccw_pkg::ST_ERASE: cmd = tccw_pkg::CMD_ERASE;
         tccw_pkg::ST_LINE: begin
            if (!stat.row_last) begin
               cmd = tccw_pkg::CMD_ROW_DOWN;
            end
         end
         tccw_pkg::ST_COPY:   cmd = tccw_pkg::CMD_COPY;
         tccw_pkg::ST_REBASE: cmd = tccw_pkg::CMD_REBASE;
         tccw_pkg::ST_BLANK:  cmd = tccw_pkg::CMD_BLANK_WRITE;
         tccw_pkg::ST_SCROLL: cmd = tccw_pkg::CMD_SCROLL;
         tccw_pkg::ST_AFTER: begin
            unique case (stat.kind)
               tccw_pkg::KIND_LF:    cmd = tccw_pkg::CMD_CR;
               tccw_pkg::KIND_PRINT: cmd = tccw_pkg::CMD_PUT;
               default:              cmd = tccw_pkg::CMD_NONE;
            endcase
         end
         tccw_pkg::ST_CLEAR: cmd = tccw_pkg::CMD_CLEAR_WRITE;
         tccw_pkg::ST_RESULT: begin
            if (stat.out_free) begin
               cmd = tccw_pkg::CMD_READ_RESULT;
            end
         end
         default: cmd = tccw_pkg::CMD_NONE;
      endcase
   end

endmodule

### src/tccw_dpath.sv
// ============================================================================
// Text console datapath
// Cell memory, cursor and view registers, configuration registers and the
// result register, driven by one controller command per cycle.
// ============================================================================
module tccw_dpath #(
   parameter int SCREEN_COLUMNS = tccw_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tccw_pkg::DEF_SCREEN_ROWS,
   parameter int MEMORY_CELLS   = tccw_pkg::DEF_MEMORY_CELLS
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request payload: tuser = opcode; tdata = char_code, read_address
   input  logic [tccw_pkg::OPCODE_W-1:0]       req_tuser,
   input  logic [tccw_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tccw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tccw_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tccw_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tccw_pkg::CSR_DATA_W-1:0]     csr_prdata,
   // Controller link
   input  tccw_pkg::cmd_type                   cmd,
   output tccw_pkg::stat_type                  stat
);

   localparam int VIEW_CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int AW         = $clog2(MEMORY_CELLS);
   localparam int COL_W      = $clog2(SCREEN_COLUMNS + 1);
   localparam int ROWS_W     = $clog2(SCREEN_ROWS);
   localparam int CNT_MAX    = (MEMORY_CELLS > VIEW_CELLS) ? MEMORY_CELLS : VIEW_CELLS;
   localparam int CNT_W      = $clog2(CNT_MAX + 1);
   localparam int SUM_W      = $clog2(MEMORY_CELLS + VIEW_CELLS + SCREEN_COLUMNS + 1);
   localparam int RA_W       = ((AW > tccw_pkg::READ_ADDR_W) ? AW : tccw_pkg::READ_ADDR_W) + 1;
   localparam int CW        = tccw_pkg::CELL_W;

   // Item registers.
   tccw_pkg::op_type                    op_ff, op_in;
   tccw_pkg::kind_type                  kind_ff, kind_in;
   logic [tccw_pkg::CHAR_W-1:0]         char_ff, char_in;

   // Console state.
   logic [AW-1:0]     view_ff, view_in;
   logic [AW-1:0]     cursor_ff, cursor_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [ROWS_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Copy pipeline: the read issued last cycle is written this cycle.
   logic              copy_pend_ff, copy_pend_in;
   logic [AW-1:0]     copy_dst_ff, copy_dst_in;

   // Configuration registers.
   logic [7:0]        attr_ff, attr_in;
   logic [CW-1:0]     blank_ff, blank_in;

   // Result register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tccw_pkg::RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   // Memory and its ports.
   logic [CW-1:0]     cell_mem_ff [MEMORY_CELLS];
   logic [CW-1:0]     rd_data_ff;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [CW-1:0]     wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;

   logic [RA_W-1:0]   raddr_ext;
   logic [RA_W-1:0]   raddr_wrap;
   logic [SUM_W-1:0]  view_end;
   logic [SUM_W-1:0]  blank_addr;
   logic [CW-1:0]     result_cell;
   logic              csr_write;

   // Read address of the incoming request folded into the memory range
   // (one subtract, so the fold holds for addresses below 2 * MEMORY_CELLS).
   always_comb begin
      raddr_ext = RA_W'(req_tdata[tccw_pkg::CHAR_W +: tccw_pkg::READ_ADDR_W]);
      if (raddr_ext >= RA_W'(MEMORY_CELLS)) begin
         raddr_wrap = raddr_ext - RA_W'(MEMORY_CELLS);
      end else begin
         raddr_wrap = raddr_ext;
      end
   end

   assign view_end   = SUM_W'(view_ff) + SUM_W'(VIEW_CELLS + SCREEN_COLUMNS);
   assign blank_addr = SUM_W'(view_ff) + SUM_W'(VIEW_CELLS) + SUM_W'(cnt_ff);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // Status toward the controller.
   always_comb begin
      stat.op          = op_ff;
      stat.kind        = kind_ff;
      stat.column_zero = (column_ff == '0);
      stat.column_wrap = (column_ff >= COL_W'(SCREEN_COLUMNS));
      stat.row_last    = (row_ff == ROWS_W'(SCREEN_ROWS - 1));
      stat.needs_copy  = (view_end >= SUM_W'(MEMORY_CELLS));
      stat.mem_last    = (cnt_ff == CNT_W'(MEMORY_CELLS - 1));
      stat.view_last   = (cnt_ff == CNT_W'(VIEW_CELLS - 1));
      stat.cols_last   = (cnt_ff == CNT_W'(SCREEN_COLUMNS - 1));
      stat.out_free    = !rsp_valid_ff || rsp_tready;
   end

   // Command decode: next values and memory port controls.
   always_comb begin
      op_in        = op_ff;
      kind_in      = kind_ff;
      char_in      = char_ff;
      view_in      = view_ff;
      cursor_in    = cursor_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      cnt_in       = '0;
      copy_pend_in = 1'b0;
      copy_dst_in  = copy_dst_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = AW'(raddr_wrap);
      result_cell  = '0;

      // A pending copy write owns the write port.
      wr_en   = copy_pend_ff;
      wr_addr = copy_dst_ff;
      wr_data = rd_data_ff;

      unique case (cmd)
         tccw_pkg::CMD_LOAD: begin
            op_in    = tccw_pkg::op_type'(req_tuser);
            char_in  = req_tdata[tccw_pkg::CHAR_W-1:0];
            kind_in  = tccw_pkg::char_kind(req_tdata[tccw_pkg::CHAR_W-1:0]);
            // Issue the cell read early; the result stage picks it up.
            rd_en    = 1'b1;
            rd_addr  = AW'(raddr_wrap);
         end
         tccw_pkg::CMD_INIT_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = AW'(cnt_ff);
            wr_data = tccw_pkg::RESET_BLANK;
            cnt_in  = cnt_ff + 1'b1;
         end
         tccw_pkg::CMD_CLEAR_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = AW'(cnt_ff);
            wr_data = blank_ff;
            cnt_in  = cnt_ff + 1'b1;
         end
         tccw_pkg::CMD_HOME: begin
            view_in   = '0;
            cursor_in = '0;
            column_in = '0;
            row_in    = '0;
         end
         tccw_pkg::CMD_BS: begin
            column_in = column_ff - 1'b1;
            cursor_in = cursor_ff - 1'b1;
         end
         tccw_pkg::CMD_ERASE: begin
            wr_en   = 1'b1;
            wr_addr = cursor_ff;
            wr_data = blank_ff;
         end
         tccw_pkg::CMD_CR: begin
            cursor_in = cursor_ff - AW'(column_ff);
            column_in = '0;
         end
         tccw_pkg::CMD_UNWRAP: begin
            column_in = column_ff - COL_W'(SCREEN_COLUMNS);
            cursor_in = cursor_ff - AW'(SCREEN_COLUMNS);
         end
         tccw_pkg::CMD_ROW_DOWN: begin
            row_in    = row_ff + 1'b1;
            cursor_in = cursor_ff + AW'(SCREEN_COLUMNS);
         end
         tccw_pkg::CMD_COPY: begin
            rd_en        = 1'b1;
            rd_addr      = view_ff + AW'(cnt_ff);
            copy_pend_in = 1'b1;
            copy_dst_in  = AW'(cnt_ff);
            cnt_in       = cnt_ff + 1'b1;
         end
         tccw_pkg::CMD_REBASE: begin
            cursor_in = cursor_ff - view_ff;
            view_in   = '0;
         end
         tccw_pkg::CMD_BLANK_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = AW'(blank_addr);
            wr_data = blank_ff;
            cnt_in  = cnt_ff + 1'b1;
         end
         tccw_pkg::CMD_SCROLL: begin
            view_in   = view_ff + AW'(SCREEN_COLUMNS);
            cursor_in = cursor_ff + AW'(SCREEN_COLUMNS);
         end
         tccw_pkg::CMD_PUT: begin
            wr_en     = 1'b1;
            wr_addr   = cursor_ff;
            wr_data   = {attr_ff, char_ff};
            cursor_in = cursor_ff + 1'b1;
            column_in = column_ff + 1'b1;
         end
         tccw_pkg::CMD_READ_RESULT: begin
            // Read items report the cell fetched at load time.
            if (op_ff == tccw_pkg::OP_READ) begin
               result_cell = rd_data_ff;
            end
            rsp_valid_in = 1'b1;
            rsp_data_in  = {2'b00,
                            result_cell,
                            tccw_pkg::ROW_W'(row_ff),
                            tccw_pkg::COLUMN_W'(column_ff),
                            tccw_pkg::OFFSET_W'(cursor_ff),
                            tccw_pkg::OFFSET_W'(view_ff)};
         end
         default: begin
         end
      endcase
   end

   // Configuration writes; bit 2 of the address selects the register.
   always_comb begin
      attr_in  = attr_ff;
      blank_in = blank_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            tccw_pkg::CSR_IDX_ATTR:  attr_in  = csr_pwdata[7:0];
            tccw_pkg::CSR_IDX_BLANK: blank_in = csr_pwdata[CW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Configuration reads.
   always_comb begin
      unique case (csr_paddr[2])
         tccw_pkg::CSR_IDX_ATTR:  csr_prdata = tccw_pkg::CSR_DATA_W'(attr_ff);
         tccw_pkg::CSR_IDX_BLANK: csr_prdata = tccw_pkg::CSR_DATA_W'(blank_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff      <= '0;
         cursor_ff    <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         attr_ff      <= tccw_pkg::RESET_ATTR;
         blank_ff     <= tccw_pkg::RESET_BLANK;
      end else begin
         view_ff      <= view_in;
         cursor_ff    <= cursor_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         copy_pend_ff <= copy_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         attr_ff      <= attr_in;
         blank_ff     <= blank_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      kind_ff     <= kind_in;
      char_ff     <= char_in;
      copy_dst_ff <= copy_dst_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Cell memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cell_mem_ff[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### src/tccw_checker.sv
// ============================================================================
// Text console checker
// Port-level checks on the console's result channel and request handshake.
// ============================================================================
module tccw_checker #(
   parameter int SCREEN_COLUMNS = tccw_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tccw_pkg::DEF_SCREEN_ROWS
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tccw_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Only one item is in work: acceptance closes the request side.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while busy");

   // A new result is only produced while an item is in work.
   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without an item in work");

   // Reported cursor row stays on the screen; the column may also equal SCREEN_COLUMNS at a pending wrap.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp_tdata[32:26]) <= SCREEN_COLUMNS) &&
                     (int'(rsp_tdata[37:33]) <= SCREEN_ROWS - 1))
      else $error("cursor position out of range");

endmodule

bind text_console_char_writer_top tccw_checker #(
   .SCREEN_COLUMNS (SCREEN_COLUMNS),
   .SCREEN_ROWS    (SCREEN_ROWS)
) u_tccw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
